FILE: sv/slx_pkg.sv
// Shared widths, types and constants for the XZ segment/line intersection pipeline.
package slx_pkg;

	localparam int CW    = 32;          // coordinate width
	localparam int EPS_W = 16;
	localparam logic [EPS_W-1:0] EPS_RST = 16'd7;
	localparam int DW1   = CW + 1;      // coordinate difference
	localparam int PW    = 2 * DW1;     // product of two differences
	localparam int SW    = PW + 1;      // den / num, signed
	localparam int MW    = PW;          // den / num magnitude
	localparam int HW    = MW / 2;      // multiplier split of num magnitude
	localparam int NW    = DW1 + MW;    // dividend magnitude
	localparam int DW    = MW;          // divisor magnitude
	localparam int QB    = CW + 4;      // quotient bits kept
	localparam int EW    = DW + QB;     // compare width in the divider
	localparam int QW    = QB + 2;      // signed quotient
	localparam int VW    = QB + 3;      // base plus quotient

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t az;
		coord_t bx;
		coord_t bz;
		coord_t cx;
		coord_t cz;
	} pts_t;

	typedef struct packed {
		coord_t base_x;
		coord_t base_z;
		coord_t ax;
		coord_t az;
		coord_t bx;
		coord_t bz;
		logic   nohit;
		logic   sn_x;
		logic   sn_z;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] n_x;
		logic [NW-1:0] n_z;
		logic [DW-1:0] d_x;
		logic [DW-1:0] d_z;
		side_t         sd;
	} div_in_t;

	typedef struct packed {
		logic [NW-1:0] r_x;
		logic [NW-1:0] r_z;
		logic [DW-1:0] d_x;
		logic [DW-1:0] d_z;
		logic [QB-1:0] q_x;
		logic [QB-1:0] q_z;
		logic          ov_x;
		logic          ov_z;
		side_t         sd;
	} div_st_t;

endpackage

FILE: sv/segment_line_intersection_xz_top.sv
// Top level of the XZ segment/line intersection pipeline.
// Intersects segment A-B with line C-D in the XZ plane (signed Q16.16) and
// returns the floor-rounded crossing with a hit flag when it lies in the box
// of A-B. One beat is accepted per clock unless the output holds; there are 6
// front stages, 37 divider stages (entry, then one quotient bit each) and 3 back stages.
// The whole pipeline holds while a finished result waits at the output.
// cfg_data sets the near-zero epsilon for x extents (reset 7).
module segment_line_intersection_xz_top
	import slx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [EPS_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// seg_start_x, seg_start_z, seg_end_x, seg_end_z, line_p_x, line_p_z, line_q_x, line_q_z
	input  logic [8*CW-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// cross_x, cross_z
	output logic [2*CW-1:0]  m_tdata,
	// hit
	output logic             m_tuser
);

	logic [EPS_W-1:0] eps_q;
	logic             en;
	pts_t             pts;
	coord_t           dx_in, dz_in;
	logic             fv, dvv;
	div_in_t          dv;
	div_st_t          res;
	coord_t           cross_x, cross_z;

	assign cfg_ready = 1'b1;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;

	assign pts.ax = s_tdata[1*CW-1:0*CW];
	assign pts.az = s_tdata[2*CW-1:1*CW];
	assign pts.bx = s_tdata[3*CW-1:2*CW];
	assign pts.bz = s_tdata[4*CW-1:3*CW];
	assign pts.cx = s_tdata[5*CW-1:4*CW];
	assign pts.cz = s_tdata[6*CW-1:5*CW];
	assign dx_in  = s_tdata[7*CW-1:6*CW];
	assign dz_in  = s_tdata[8*CW-1:7*CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	slx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.eps       (eps_q),
		.pts       (pts),
		.dx_in     (dx_in),
		.dz_in     (dz_in),
		.out_valid (fv),
		.dv        (dv)
	);

	slx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fv),
		.dv        (dv),
		.out_valid (dvv),
		.res       (res)
	);

	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dvv),
		.res       (res),
		.out_valid (m_tvalid),
		.hit       (m_tuser),
		.cross_x   (cross_x),
		.cross_z   (cross_z)
	);

	assign m_tdata = {cross_z, cross_x};

endmodule

FILE: sv/slx_front.sv
// Front stages: differences, products, cross terms, magnitudes and dividend build.
module slx_front
	import slx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [EPS_W-1:0] eps,
	input  pts_t             pts,
	input  coord_t           dx_in,
	input  coord_t           dz_in,
	output logic             out_valid,
	output div_in_t          dv
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// s1
	logic signed [DW1-1:0] rx_s1, rz_s1, sx_s1, sz_s1, ex_s1, ez_s1, fx_s1;
	pts_t pts_s1;
	// s2
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic [DW1-1:0] rxm_s2, rzm_s2, sxm_s2;
	logic rxn_s2, rzn_s2, sxn_s2, vab_s2, vcd_s2;
	pts_t pts_s2;
	// s3
	logic signed [SW-1:0] den_s3, num_s3;
	logic signed [PW-1:0] p5_s3, p6_s3;
	logic [DW1-1:0] rxm_s3, rzm_s3, sxm_s3;
	logic rxn_s3, rzn_s3, sxn_s3, vab_s3, vcd_s3;
	pts_t pts_s3;
	// s4
	logic [MW-1:0] denm_s4, numm_s4, p5m_s4, p6m_s4;
	logic denn_s4, dz_s4, numn_s4, p5n_s4, p6n_s4;
	logic [DW1-1:0] rxm_s4, rzm_s4, sxm_s4;
	logic rxn_s4, rzn_s4, sxn_s4, vab_s4, vcd_s4;
	pts_t pts_s4;
	// s5
	logic [PW-1:0] ppxl_s5, ppxh_s5, ppzl_s5, ppzh_s5;
	logic [MW-1:0] denm_s5, p5m_s5, p6m_s5;
	logic denn_s5, dz_s5, numn_s5, p5n_s5, p6n_s5;
	logic [DW1-1:0] rxm_s5, sxm_s5;
	logic rxn_s5, rzn_s5, sxn_s5, vab_s5, vcd_s5;
	pts_t pts_s5;

	logic [DW1-1:0] rxm_c, rzm_c, sxm_c;
	logic signed [SW-1:0] den_c, num_c;
	logic [NW-1:0] nx_c, nz_c;

	assign rxm_c = rx_s1[DW1-1] ? DW1'(-rx_s1) : DW1'(rx_s1);
	assign rzm_c = rz_s1[DW1-1] ? DW1'(-rz_s1) : DW1'(rz_s1);
	assign sxm_c = sx_s1[DW1-1] ? DW1'(-sx_s1) : DW1'(sx_s1);
	assign den_c = SW'(p1_s2) - SW'(p2_s2);
	assign num_c = SW'(p3_s2) - SW'(p4_s2);
	assign nx_c  = (NW'(ppxh_s5) << HW) + NW'(ppxl_s5);
	assign nz_c  = (NW'(ppzh_s5) << HW) + NW'(ppzl_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1  <= DW1'(pts.bx) - DW1'(pts.ax);
			rz_s1  <= DW1'(pts.bz) - DW1'(pts.az);
			sx_s1  <= DW1'(dx_in) - DW1'(pts.cx);
			sz_s1  <= DW1'(dz_in) - DW1'(pts.cz);
			ex_s1  <= DW1'(pts.cx) - DW1'(pts.ax);
			ez_s1  <= DW1'(pts.cz) - DW1'(pts.az);
			fx_s1  <= DW1'(pts.bx) - DW1'(pts.cx);
			pts_s1 <= pts;

			p1_s2  <= rx_s1 * sz_s1;
			p2_s2  <= rz_s1 * sx_s1;
			p3_s2  <= ex_s1 * sz_s1;
			p4_s2  <= ez_s1 * sx_s1;
			p5_s2  <= fx_s1 * sz_s1;
			p6_s2  <= ex_s1 * rz_s1;
			rxm_s2 <= rxm_c;
			rzm_s2 <= rzm_c;
			sxm_s2 <= sxm_c;
			rxn_s2 <= rx_s1[DW1-1];
			rzn_s2 <= rz_s1[DW1-1];
			sxn_s2 <= sx_s1[DW1-1];
			vab_s2 <= (rxm_c == '0) || (rxm_c < DW1'(eps));
			vcd_s2 <= (sxm_c == '0) || (sxm_c < DW1'(eps));
			pts_s2 <= pts_s1;

			den_s3 <= den_c;
			num_s3 <= num_c;
			p5_s3  <= p5_s2;
			p6_s3  <= p6_s2;
			rxm_s3 <= rxm_s2;
			rzm_s3 <= rzm_s2;
			sxm_s3 <= sxm_s2;
			rxn_s3 <= rxn_s2;
			rzn_s3 <= rzn_s2;
			sxn_s3 <= sxn_s2;
			vab_s3 <= vab_s2;
			vcd_s3 <= vcd_s2;
			pts_s3 <= pts_s2;

			denm_s4 <= den_s3[SW-1] ? MW'(-den_s3) : MW'(den_s3);
			numm_s4 <= num_s3[SW-1] ? MW'(-num_s3) : MW'(num_s3);
			p5m_s4  <= p5_s3[PW-1] ? MW'(-p5_s3) : MW'(p5_s3);
			p6m_s4  <= p6_s3[PW-1] ? MW'(-p6_s3) : MW'(p6_s3);
			denn_s4 <= den_s3[SW-1];
			dz_s4   <= (den_s3 == '0);
			numn_s4 <= num_s3[SW-1];
			p5n_s4  <= p5_s3[PW-1];
			p6n_s4  <= p6_s3[PW-1];
			rxm_s4  <= rxm_s3;
			rzm_s4  <= rzm_s3;
			sxm_s4  <= sxm_s3;
			rxn_s4  <= rxn_s3;
			rzn_s4  <= rzn_s3;
			sxn_s4  <= sxn_s3;
			vab_s4  <= vab_s3;
			vcd_s4  <= vcd_s3;
			pts_s4  <= pts_s3;

			ppxl_s5 <= rxm_s4 * numm_s4[HW-1:0];
			ppxh_s5 <= rxm_s4 * numm_s4[MW-1:HW];
			ppzl_s5 <= rzm_s4 * numm_s4[HW-1:0];
			ppzh_s5 <= rzm_s4 * numm_s4[MW-1:HW];
			denm_s5 <= denm_s4;
			p5m_s5  <= p5m_s4;
			p6m_s5  <= p6m_s4;
			denn_s5 <= denn_s4;
			dz_s5   <= dz_s4;
			numn_s5 <= numn_s4;
			p5n_s5  <= p5n_s4;
			p6n_s5  <= p6n_s4;
			rxm_s5  <= rxm_s4;
			sxm_s5  <= sxm_s4;
			rxn_s5  <= rxn_s4;
			rzn_s5  <= rzn_s4;
			sxn_s5  <= sxn_s4;
			vab_s5  <= vab_s4;
			vcd_s5  <= vcd_s4;
			pts_s5  <= pts_s4;

			dv.sd.ax    <= pts_s5.ax;
			dv.sd.az    <= pts_s5.az;
			dv.sd.bx    <= pts_s5.bx;
			dv.sd.bz    <= pts_s5.bz;
			dv.sd.nohit <= (vab_s5 && vcd_s5) || (!vab_s5 && !vcd_s5 && dz_s5);
			if (!vab_s5 && !vcd_s5) begin
				dv.n_x       <= nx_c;
				dv.n_z       <= nz_c;
				dv.d_x       <= denm_s5;
				dv.d_z       <= denm_s5;
				dv.sd.sn_x   <= rxn_s5 ^ numn_s5 ^ denn_s5;
				dv.sd.sn_z   <= rzn_s5 ^ numn_s5 ^ denn_s5;
				dv.sd.base_x <= pts_s5.ax;
				dv.sd.base_z <= pts_s5.az;
			end else if (vab_s5) begin
				dv.n_x       <= '0;
				dv.n_z       <= NW'(p5m_s5);
				dv.d_x       <= DW'(1);
				dv.d_z       <= DW'(sxm_s5);
				dv.sd.sn_x   <= 1'b0;
				dv.sd.sn_z   <= p5n_s5 ^ sxn_s5;
				dv.sd.base_x <= pts_s5.bx;
				dv.sd.base_z <= pts_s5.cz;
			end else begin
				dv.n_x       <= '0;
				dv.n_z       <= NW'(p6m_s5);
				dv.d_x       <= DW'(1);
				dv.d_z       <= DW'(rxm_s5);
				dv.sd.sn_x   <= 1'b0;
				dv.sd.sn_z   <= p6n_s5 ^ rxn_s5;
				dv.sd.base_x <= pts_s5.cx;
				dv.sd.base_z <= pts_s5.az;
			end
		end
	end

endmodule

FILE: sv/slx_div.sv
// Pipelined restoring divider pair, one quotient bit per stage, with range check.
module slx_div
	import slx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  div_in_t dv,
	output logic    out_valid,
	output div_st_t res
);

	div_st_t st [0:QB];
	logic    vd [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd[0] <= 1'b0;
		end else if (en) begin
			vd[0] <= in_valid;
		end
	end

	// quotient magnitude must fit QB bits, otherwise it is out of any box
	always_ff @(posedge clk) begin
		if (en) begin
			st[0].r_x  <= dv.n_x;
			st[0].r_z  <= dv.n_z;
			st[0].d_x  <= dv.d_x;
			st[0].d_z  <= dv.d_z;
			st[0].q_x  <= '0;
			st[0].q_z  <= '0;
			st[0].ov_x <= EW'(dv.n_x) >= (EW'(dv.d_x) << QB);
			st[0].ov_z <= EW'(dv.n_z) >= (EW'(dv.d_z) << QB);
			st[0].sd   <= dv.sd;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_stage
		localparam int K = QB - j;
		logic [EW-1:0] shx, shz;
		logic          gex, gez;

		assign shx = EW'(st[j-1].d_x) << K;
		assign shz = EW'(st[j-1].d_z) << K;
		assign gex = EW'(st[j-1].r_x) >= shx;
		assign gez = EW'(st[j-1].r_z) >= shz;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd[j] <= 1'b0;
			end else if (en) begin
				vd[j] <= vd[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st[j].r_x  <= gex ? st[j-1].r_x - shx[NW-1:0] : st[j-1].r_x;
				st[j].r_z  <= gez ? st[j-1].r_z - shz[NW-1:0] : st[j-1].r_z;
				st[j].d_x  <= st[j-1].d_x;
				st[j].d_z  <= st[j-1].d_z;
				st[j].q_x  <= {st[j-1].q_x[QB-2:0], gex};
				st[j].q_z  <= {st[j-1].q_z[QB-2:0], gez};
				st[j].ov_x <= st[j-1].ov_x;
				st[j].ov_z <= st[j-1].ov_z;
				st[j].sd   <= st[j-1].sd;
			end
		end
	end

	assign out_valid = vd[QB];
	assign res       = st[QB];

endmodule

FILE: sv/slx_back.sv
// Back stages: floor sign fixup, base add, bounding box test and output register.
module slx_back
	import slx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  div_st_t res,
	output logic    out_valid,
	output logic    hit,
	output coord_t  cross_x,
	output coord_t  cross_z
);

	logic v_b1, v_b2;
	logic signed [QW-1:0] qx_b1, qz_b1;
	logic                 ok_b1, ok_b2;
	side_t                sd_b1, sd_b2;
	logic signed [VW-1:0] vx_b2, vz_b2;

	logic [QB:0]          qax, qaz;
	logic signed [VW-1:0] lox, hix, loz, hiz;
	logic                 inbox;

	assign qax = {1'b0, res.q_x} + (QB+1)'(res.sd.sn_x && (res.r_x != '0));
	assign qaz = {1'b0, res.q_z} + (QB+1)'(res.sd.sn_z && (res.r_z != '0));

	assign lox = (sd_b2.ax < sd_b2.bx) ? VW'(sd_b2.ax) : VW'(sd_b2.bx);
	assign hix = (sd_b2.ax < sd_b2.bx) ? VW'(sd_b2.bx) : VW'(sd_b2.ax);
	assign loz = (sd_b2.az < sd_b2.bz) ? VW'(sd_b2.az) : VW'(sd_b2.bz);
	assign hiz = (sd_b2.az < sd_b2.bz) ? VW'(sd_b2.bz) : VW'(sd_b2.az);
	assign inbox = (lox <= vx_b2) && (vx_b2 <= hix) && (loz <= vz_b2) && (vz_b2 <= hiz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			out_valid <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_b1 <= res.sd.sn_x ? -$signed({1'b0, qax}) : $signed({1'b0, qax});
			qz_b1 <= res.sd.sn_z ? -$signed({1'b0, qaz}) : $signed({1'b0, qaz});
			ok_b1 <= !res.sd.nohit && !res.ov_x && !res.ov_z;
			sd_b1 <= res.sd;

			vx_b2 <= VW'(sd_b1.base_x) + VW'(qx_b1);
			vz_b2 <= VW'(sd_b1.base_z) + VW'(qz_b1);
			ok_b2 <= ok_b1;
			sd_b2 <= sd_b1;

			hit     <= ok_b2 && inbox;
			cross_x <= (ok_b2 && inbox) ? vx_b2[CW-1:0] : '0;
			cross_z <= (ok_b2 && inbox) ? vz_b2[CW-1:0] : '0;
		end
	end

endmodule

FILE: tb/sv/segment_line_intersection_xz_top_test.sv
// Testbench for the XZ segment/line intersection pipeline, checked against a floor-exact predictor.
`timescale 1ns / 1ps
module segment_line_intersection_xz_top_test;
	import slx_pkg::*;

	localparam int LATENCY = 46;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		coord_t qz;
		coord_t qx;
		coord_t pz;
		coord_t px;
		coord_t bz;
		coord_t bx;
		coord_t az;
		coord_t ax;
	} seg_line_t;

	typedef struct packed {
		logic   hit;
		coord_t cx;
		coord_t cz;
	} crossing_t;

	typedef struct {
		seg_line_t pts;
		logic      known;
		crossing_t res;
	} vector_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [EPS_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [8*CW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [2*CW-1:0] m_tdata;
	logic m_tuser;

	logic [EPS_W-1:0] epsilon;
	crossing_t crossing_q[$];
	int errors;
	int n_hits;
	int n_results;
	int idle_cycles;
	bit hold_off;
	bit long_hold;

	segment_line_intersection_xz_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [259:0] floor_div(logic signed [259:0] n,
			logic signed [259:0] d);
		logic signed [259:0] q;
		q = n / d;
		if ((n % d != 0) && ((n < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic bit is_flat(logic signed [63:0] v, logic [EPS_W-1:0] eps);
		logic [63:0] mag;
		mag = v < 0 ? -v : v;
		return mag == 0 || mag < eps;
	endfunction

	function automatic crossing_t cross_segment(seg_line_t p, logic [EPS_W-1:0] eps);
		logic signed [259:0] ax, az, bx, bz, cx, cz, dx, dz, rx, rz, sx, sz, den, num, x, z;
		bit vab, vcd;
		crossing_t r;
		ax = p.ax; az = p.az; bx = p.bx; bz = p.bz;
		cx = p.px; cz = p.pz; dx = p.qx; dz = p.qz;
		rx = bx - ax; rz = bz - az; sx = dx - cx; sz = dz - cz;
		vab = is_flat(rx[63:0], eps);
		vcd = is_flat(sx[63:0], eps);
		r = '{1'b0, '0, '0};
		if (vab && vcd)
			return r;
		if (!vab && !vcd) begin
			den = rx * sz - rz * sx;
			if (den == 0)
				return r;
			num = (cx - ax) * sz - (cz - az) * sx;
			x = ax + floor_div(rx * num, den);
			z = az + floor_div(rz * num, den);
		end else if (vab) begin
			x = bx;
			z = cz + floor_div((bx - cx) * sz, sx);
		end else begin
			x = cx;
			z = az + floor_div((cx - ax) * rz, rx);
		end
		if (x >= (ax < bx ? ax : bx) && x <= (ax < bx ? bx : ax) &&
				z >= (az < bz ? az : bz) && z <= (az < bz ? bz : az)) begin
			r.hit = 1'b1;
			r.cx = x[31:0];
			r.cz = z[31:0];
		end
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2000)) - 1000;
			2: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			3: return $signed($urandom_range(0, 32'h20000000)) - 32'sh10000000;
			4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h02000000)) - 32'sh01000000;
		endcase
	endfunction

	function automatic seg_line_t rand_points();
		seg_line_t p;
		coord_t d;
		p.ax = rand_coord(); p.az = rand_coord();
		p.bx = rand_coord(); p.bz = rand_coord();
		case ($urandom_range(0, 7))
			0: p.bx = p.ax + $signed($urandom_range(0, 16)) - 8;
			1: begin
				// line through the segment interior so hits are common
				p.px = p.ax + (p.bx - p.ax) / 2 + $signed($urandom_range(0, 64)) - 32;
				p.pz = p.az + (p.bz - p.az) / 2;
				p.qx = p.px + rand_coord() / 4;
				p.qz = p.pz + rand_coord() / 4;
				return p;
			end
			2: begin
				// same direction: parallel or collinear
				d = $signed($urandom_range(1, 5));
				p.px = rand_coord(); p.pz = rand_coord();
				p.qx = p.px + (p.bx - p.ax) / d;
				p.qz = p.pz + (p.bz - p.az) / d;
				if ($urandom_range(0, 1)) begin
					p.qx = p.bx - p.ax; p.qz = p.bz - p.az;
					p.px = 0; p.pz = 0;
				end
				return p;
			end
			default: ;
		endcase
		p.px = rand_coord(); p.pz = rand_coord();
		p.qx = $urandom_range(0, 3) == 0 ? p.px + $signed($urandom_range(0, 16)) - 8
			: rand_coord();
		p.qz = rand_coord();
		return p;
	endfunction

	task automatic send_points(seg_line_t p);
		s_tdata <= p;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		crossing_q.push_back(cross_segment(p, epsilon));
		@(negedge clk);
	endtask

	task automatic drain_and_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (crossing_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_epsilon(logic [EPS_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		epsilon = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		int burst;
		int k;
		k = 0;
		while (k < count) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && k < count) begin
				send_points(rand_points());
				burst--;
				k++;
			end
			if (k < count && $urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	// receiver stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (long_hold)
			m_tready <= 1'b0;
		else if (hold_off)
			m_tready <= ($urandom_range(0, 3) != 0);
		else
			m_tready <= 1'b1;
	end

	initial begin
		hold_off = 0;
		long_hold = 0;
		wait (arst_n);
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			hold_off = ~hold_off;
		end
	end

	always @(posedge clk) begin
		crossing_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (crossing_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result hit=%0b data=%h", $time, m_tuser, m_tdata);
			end else begin
				exp_r = crossing_q.pop_front();
				if (exp_r.hit)
					n_hits++;
				if (m_tuser !== exp_r.hit || m_tdata[31:0] !== exp_r.cx
						|| m_tdata[63:32] !== exp_r.cz) begin
					errors++;
					$display("%0t: mismatch expected hit=%0b x=%h z=%h actual hit=%0b x=%h z=%h",
						$time, exp_r.hit, exp_r.cx, exp_r.cz, m_tuser,
						m_tdata[31:0], m_tdata[63:32]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || long_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("segment_line_intersection_xz_top_test: done, errors");
			$finish;
		end
	end

	initial begin
		vector_t directed[$];
		int k;
		errors = 0;
		n_hits = 0;
		n_results = 0;
		idle_cycles = 0;
		epsilon = EPS_RST;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all zero: both vertical
		directed.push_back('{'0, 1'b1, '{1'b0, '0, '0}});
		// horizontal segment (0,0)-(2,0), vertical line x=1
		directed.push_back('{'{qz: 32'sh00010000, qx: 32'sh00010000, pz: -32'sh00010000,
			px: 32'sh00010000, bz: 0, bx: 32'sh00020000, az: 0, ax: 0},
			1'b1, '{1'b1, 32'sh00010000, 0}});
		// parallel lines
		directed.push_back('{'{qz: 32'sh00030000, qx: 32'sh00020000, pz: 32'sh00010000,
			px: 0, bz: 32'sh00020000, bx: 32'sh00020000, az: 0, ax: 0},
			1'b1, '{1'b0, 0, 0}});
		// diagonal crossing at (1,1)
		directed.push_back('{'{qz: 0, qx: 32'sh00020000, pz: 32'sh00020000, px: 0,
			bz: 32'sh00020000, bx: 32'sh00020000, az: 0, ax: 0},
			1'b1, '{1'b1, 32'sh00010000, 32'sh00010000}});
		// line x extent 3 LSB: vertical under reset epsilon
		directed.push_back('{'{qz: 32'sh00050000, qx: 32'sh00000003, pz: -32'sh00050000,
			px: 0, bz: 32'sh00010000, bx: -32'sh00010000, az: 0, ax: 32'sh00010000},
			1'b0, '{1'b0, 0, 0}});
		// extremes of the coordinate range
		directed.push_back('{'{qz: 32'sh7fffffff, qx: 32'sh80000000, pz: 32'sh80000000,
			px: 32'sh7fffffff, bz: 32'sh7fffffff, bx: 32'sh7fffffff, az: 32'sh80000000,
			ax: 32'sh80000000}, 1'b0, '{1'b0, 0, 0}});
		directed.push_back('{'{qz: 32'sh80000000, qx: 32'sh80000000, pz: 32'sh7fffffff,
			px: 32'sh7fffffff, bz: 32'sh80000000, bx: 32'sh7fffffff, az: 32'sh7fffffff,
			ax: 32'sh80000000}, 1'b0, '{1'b0, 0, 0}});
		directed.push_back('{'{qz: 32'sh00000005, qx: 32'sh7fffffff, pz: -32'sh00000005,
			px: 32'sh80000000, bz: 32'sh7fffffff, bx: 32'sh00000001, az: 32'sh80000000,
			ax: 0}, 1'b0, '{1'b0, 0, 0}});
		// rounding toward minus infinity on a negative quotient
		directed.push_back('{'{qz: -32'sh00000001, qx: 32'sh00000003, pz: 0, px: 0,
			bz: 32'sh00000007, bx: -32'sh00000011, az: -32'sh00000003, ax: 32'sh00000013},
			1'b0, '{1'b0, 0, 0}});
		// segment vertical, line sloped
		directed.push_back('{'{qz: 32'sh00030000, qx: 32'sh00030000, pz: 0, px: 0,
			bz: 32'sh00040000, bx: 32'sh00010000, az: -32'sh00040000, ax: 32'sh00010000},
			1'b1, '{1'b1, 32'sh00010000, 32'sh00010000}});
		// crossing outside the box
		directed.push_back('{'{qz: 32'sh00090000, qx: 32'sh00050000, pz: -32'sh00090000,
			px: 32'sh00050000, bz: 0, bx: 32'sh00020000, az: 0, ax: 0},
			1'b1, '{1'b0, 0, 0}});

		foreach (directed[i]) begin
			if (directed[i].known && cross_segment(directed[i].pts, epsilon)
					!= directed[i].res) begin
				errors++;
				$display("%0t: directed row %0d predictor disagrees with typed result",
					$time, i);
			end
			send_points(directed[i].pts);
		end
		drain_and_idle();

		// zero epsilon: only an exact zero extent is vertical
		write_epsilon(16'd0);
		for (k = 0; k < 8; k++)
			send_points(directed[k % directed.size()].pts);
		run_random(200);
		drain_and_idle();

		// long receiver hold-off while the sender keeps going
		fork
			begin
				long_hold = 1;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end
			run_random(150);
		join
		drain_and_idle();

		write_epsilon(16'hffff);
		run_random(300);
		drain_and_idle();

		write_epsilon(16'd300);
		run_random(250);
		drain_and_idle();

		write_epsilon(EPS_RST);
		run_random(250);
		drain_and_idle();

		$display("covered %0d results, %0d hits, epsilon at 0, 7, 300 and 65535",
			n_results, n_hits);
		if (errors == 0)
			$display("segment_line_intersection_xz_top_test: done, clean");
		else
			$display("segment_line_intersection_xz_top_test: done, errors");
		$finish;
	end

endmodule
